// File: rtl/rgbgim_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgbgim_pkg
// Shared constants and types of the RGB grayscale / inversion / mirror block.
// ----------------------------------------------------------------------------
package rgbgim_pkg;

	// Line buffer geometry and sample width
	localparam int MAX_WIDTH   = 64;
	localparam int ADDR_W      = $clog2(MAX_WIDTH);
	localparam int COUNT_W     = ADDR_W + 1;
	localparam int SAMPLE_BITS = 16;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	// Luma weights, Q0.16
	localparam logic [15:0] W_RED   = 16'd19589;
	localparam logic [15:0] W_GREEN = 16'd38470;
	localparam logic [15:0] W_BLUE  = 16'd7471;

	// Mode codes
	localparam logic [1:0] MODE_GRAY   = 2'd0;
	localparam logic [1:0] MODE_INV    = 2'd1;
	localparam logic [1:0] MODE_MIRROR = 2'd2;
	localparam logic [1:0] MODE_ALT    = 2'd3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL = 2'd2;

	// Register reset values
	localparam logic [1:0]         RST_MODE      = MODE_GRAY;
	localparam logic [COUNT_W-1:0] RST_ROW_WIDTH = COUNT_W'(MAX_WIDTH);
	localparam logic [15:0]        RST_MAX_LEVEL = 16'd255;

	// Command passed from front to back
	typedef struct packed {
		logic [1:0]             mode;
		logic [15:0]            red;
		logic [15:0]            green;
		logic [15:0]            blue;
		logic                   last;
		logic [ADDR_W-1:0]      pos;
	} cmd_t;

	// Line buffer write request
	typedef struct packed {
		logic                   en;
		logic [ADDR_W-1:0]      addr;
		logic [47:0]            data;
	} wr_t;

endpackage
`default_nettype wire

// File: rtl/rgb_pixel_gray_invert_mirror.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_pixel_gray_invert_mirror
// RGB pixel stream processor: grayscale, inversion or horizontal mirror.
// ----------------------------------------------------------------------------
// Pixels enter on the in_valid / in_stall channel and results leave on the
// out_valid / out_stall channel. In grayscale and inversion mode each pixel
// gives one result: the back end pops it from the command queue into its
// command register, then loads the luma sum or inversion into the output
// register, and it pops no new pixel before that load; row_end marks the last
// pixel of each row. In mirror mode a row is stored in a 64-entry line buffer
// and, on its last pixel, emitted last-first, as the sequencer alternates a
// line buffer read with an output register load; input is held off until the
// burst ends. Output stalls hold the sequencer and the output register.
// Registers:
// 0 mode, 1 row width, 2 max level; write them only while the block is idle.
// ----------------------------------------------------------------------------
module rgb_pixel_gray_invert_mirror (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [rgbgim_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [rgbgim_pkg::CFG_W-1:0]       cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [15:0]                        red_in,
	input  wire logic [15:0]                        green_in,
	input  wire logic [15:0]                        blue_in,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [15:0]                             red_out,
	output logic [15:0]                             green_out,
	output logic [15:0]                             blue_out,
	output logic                                    row_end
);

	logic [1:0]                        mode_q;
	logic [rgbgim_pkg::COUNT_W-1:0]    row_width_q;
	logic [15:0]                       max_level_q;
	logic                              q_full;
	logic                              q_push;
	logic                              q_pop;
	logic                              q_not_empty;
	rgbgim_pkg::cmd_t                  push_cmd;
	rgbgim_pkg::cmd_t                  head_cmd;
	rgbgim_pkg::wr_t                   wr;
	logic                              burst_done;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= rgbgim_pkg::RST_MODE;
			row_width_q <= rgbgim_pkg::RST_ROW_WIDTH;
			max_level_q <= rgbgim_pkg::RST_MAX_LEVEL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rgbgim_pkg::CFG_MODE: begin
					mode_q <= cfg_data[1:0];
				end
				rgbgim_pkg::CFG_ROW_WIDTH: begin
					row_width_q <= cfg_data[rgbgim_pkg::COUNT_W-1:0];
				end
				rgbgim_pkg::CFG_MAX_LEVEL: begin
					max_level_q <= cfg_data[15:0];
				end
				default: begin
					mode_q <= mode_q;
				end
			endcase
		end
	end

	rgbgim_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.red_in     (red_in),
		.green_in   (green_in),
		.blue_in    (blue_in),
		.mode       (mode_q),
		.row_width  (row_width_q),
		.q_full     (q_full),
		.q_push     (q_push),
		.cmd        (push_cmd),
		.wr         (wr),
		.burst_done (burst_done)
	);

	rgbgim_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head       (head_cmd),
		.not_empty  (q_not_empty)
	);

	rgbgim_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (head_cmd),
		.cmd_valid  (q_not_empty),
		.cmd_pop    (q_pop),
		.wr         (wr),
		.max_level  (max_level_q),
		.burst_done (burst_done),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.red_out    (red_out),
		.green_out  (green_out),
		.blue_out   (blue_out),
		.row_end    (row_end)
	);

endmodule
`default_nettype wire

// File: rtl/rgbgim_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgbgim_front
// Accepts pixels, tracks the column, writes the line buffer and issues
// commands to the back end. Holds off input during a mirror burst.
// ----------------------------------------------------------------------------
module rgbgim_front (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [15:0]                     red_in,
	input  wire logic [15:0]                     green_in,
	input  wire logic [15:0]                     blue_in,
	input  wire logic [1:0]                      mode,
	input  wire logic [rgbgim_pkg::COUNT_W-1:0]  row_width,
	input  wire logic                            q_full,
	output logic                                 q_push,
	output rgbgim_pkg::cmd_t                     cmd,
	output rgbgim_pkg::wr_t                      wr,
	input  wire logic                            burst_done
);

	logic [rgbgim_pkg::ADDR_W-1:0]  pos_q;
	logic                           busy_q;
	logic [rgbgim_pkg::COUNT_W-1:0] n;
	logic [rgbgim_pkg::COUNT_W-1:0] eff_width;
	logic                           last;
	logic                           accept;
	logic                           is_mirror;

	// Clamp row width into 1..MAX_WIDTH
	always_comb begin
		if (row_width == '0) begin
			eff_width = rgbgim_pkg::COUNT_W'(1);
		end else if (row_width > rgbgim_pkg::COUNT_W'(rgbgim_pkg::MAX_WIDTH)) begin
			eff_width = rgbgim_pkg::COUNT_W'(rgbgim_pkg::MAX_WIDTH);
		end else begin
			eff_width = row_width;
		end
	end

	assign n         = {1'b0, pos_q} + rgbgim_pkg::COUNT_W'(1);
	assign last      = (n >= eff_width);
	assign is_mirror = (mode == rgbgim_pkg::MODE_MIRROR) || (mode == rgbgim_pkg::MODE_ALT);
	assign in_stall  = busy_q || q_full;
	assign accept    = in_valid && !in_stall;

	// Issue a command for every pixel that yields results
	assign q_push    = accept && (!is_mirror || last);
	assign cmd.mode  = mode;
	assign cmd.red   = red_in;
	assign cmd.green = green_in;
	assign cmd.blue  = blue_in;
	assign cmd.last  = last;
	assign cmd.pos   = pos_q;

	// Store every incoming pixel unmodified
	assign wr.en   = accept;
	assign wr.addr = pos_q;
	assign wr.data = {red_in, green_in, blue_in};

	// Advance the column; hold input while a mirror burst drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			busy_q <= 1'b0;
		end else begin
			if (accept) begin
				pos_q <= last ? '0 : n[rgbgim_pkg::ADDR_W-1:0];
			end
			if (q_push && is_mirror) begin
				busy_q <= 1'b1;
			end else if (burst_done) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/rgbgim_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgbgim_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module rgbgim_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire rgbgim_pkg::cmd_t  push_cmd,
	output logic                   full,
	input  wire logic              pop,
	output rgbgim_pkg::cmd_t       head,
	output logic                   not_empty
);

	rgbgim_pkg::cmd_t                 entry_q [rgbgim_pkg::QUEUE_DEPTH];
	logic [rgbgim_pkg::QPTR_W-1:0]    wptr_q;
	logic [rgbgim_pkg::QPTR_W-1:0]    rptr_q;
	logic [rgbgim_pkg::QCNT_W-1:0]    count_q;
	logic                             do_push;
	logic                             do_pop;

	assign full      = (count_q == rgbgim_pkg::QCNT_W'(rgbgim_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head      = entry_q[rptr_q];

	// Store requests
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wptr_q] <= push_cmd;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + rgbgim_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rptr_q <= rptr_q + rgbgim_pkg::QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + rgbgim_pkg::QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - rgbgim_pkg::QCNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/rgbgim_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgbgim_back
// Carries out commands: luma, inversion, or reverse read-out of the line
// buffer. Owns the line buffer and the output register.
// ----------------------------------------------------------------------------
module rgbgim_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rgbgim_pkg::cmd_t  cmd,
	input  wire logic              cmd_valid,
	output logic                   cmd_pop,
	input  wire rgbgim_pkg::wr_t   wr,
	input  wire logic [15:0]       max_level,
	output logic                   burst_done,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [15:0]            red_out,
	output logic [15:0]            green_out,
	output logic [15:0]            blue_out,
	output logic                   row_end
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_GRAY = 3'd1;
	localparam logic [2:0] ST_INV  = 3'd2;
	localparam logic [2:0] ST_MRD  = 3'd3;
	localparam logic [2:0] ST_MWR  = 3'd4;

	logic [2:0]                     state_q;
	rgbgim_pkg::cmd_t               cmd_q;
	logic [31:0]                    prod_r_q;
	logic [31:0]                    prod_g_q;
	logic [31:0]                    prod_b_q;
	logic [33:0]                    luma_sum;
	logic [rgbgim_pkg::ADDR_W-1:0]  addr_q;
	logic [47:0]                    mem_q [rgbgim_pkg::MAX_WIDTH];
	logic [47:0]                    rd_q;
	logic                           out_valid_q;
	logic [15:0]                    red_q;
	logic [15:0]                    green_q;
	logic [15:0]                    blue_q;
	logic                           row_end_q;
	logic                           out_free;
	logic                           is_mirror;
	logic [15:0]                    inv_r;
	logic [15:0]                    inv_g;
	logic [15:0]                    inv_b;

	// Line buffer: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		rd_q <= mem_q[addr_q];
	end

	assign out_free  = !out_valid_q || !out_stall;
	assign is_mirror = (cmd.mode == rgbgim_pkg::MODE_MIRROR) ||
	                   (cmd.mode == rgbgim_pkg::MODE_ALT);
	assign cmd_pop   = (state_q == ST_IDLE) && cmd_valid;
	assign luma_sum  = {2'b00, prod_r_q} + {2'b00, prod_g_q} + {2'b00, prod_b_q};

	// Invert against max level, floor at zero
	assign inv_r = (max_level > cmd_q.red)   ? (max_level - cmd_q.red)   : '0;
	assign inv_g = (max_level > cmd_q.green) ? (max_level - cmd_q.green) : '0;
	assign inv_b = (max_level > cmd_q.blue)  ? (max_level - cmd_q.blue)  : '0;

	assign burst_done = (state_q == ST_MWR) && out_free && (addr_q == '0);

	// Luma products, one multiplier per channel
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q    <= cmd;
			prod_r_q <= cmd.red   * rgbgim_pkg::W_RED;
			prod_g_q <= cmd.green * rgbgim_pkg::W_GREEN;
			prod_b_q <= cmd.blue  * rgbgim_pkg::W_BLUE;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			addr_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						if (is_mirror) begin
							addr_q  <= cmd.pos;
							state_q <= ST_MRD;
						end else if (cmd.mode == rgbgim_pkg::MODE_INV) begin
							state_q <= ST_INV;
						end else begin
							state_q <= ST_GRAY;
						end
					end
				end
				ST_GRAY, ST_INV: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_MRD: begin
					state_q <= ST_MWR;
				end
				ST_MWR: begin
					if (out_free) begin
						if (addr_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							addr_q  <= addr_q - rgbgim_pkg::ADDR_W'(1);
							state_q <= ST_MRD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= (state_q == ST_GRAY) || (state_q == ST_INV) ||
			               (state_q == ST_MWR);
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (out_free) begin
			case (state_q)
				ST_GRAY: begin
					red_q     <= luma_sum[31:16];
					green_q   <= luma_sum[31:16];
					blue_q    <= luma_sum[31:16];
					row_end_q <= cmd_q.last;
				end
				ST_INV: begin
					red_q     <= inv_r;
					green_q   <= inv_g;
					blue_q    <= inv_b;
					row_end_q <= cmd_q.last;
				end
				ST_MWR: begin
					red_q     <= rd_q[47:32];
					green_q   <= rd_q[31:16];
					blue_q    <= rd_q[15:0];
					row_end_q <= (addr_q == '0);
				end
				default: begin
					row_end_q <= row_end_q;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign red_out   = red_q;
	assign green_out = green_q;
	assign blue_out  = blue_q;
	assign row_end   = row_end_q;

endmodule
`default_nettype wire

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the RGB grayscale / inversion / mirror block.
// ----------------------------------------------------------------------------
// A short table of directed pixels and register writes runs first. It covers
// the sample extremes, every mode including the spare mirror code, row width
// zero, row widths lowered and modes changed part-way through a row, and
// inversion against the largest max level and a max level of one. Random phases with
// fresh register settings follow. A local predictor keeps its own column
// count and line buffer and queues the pixels each request should produce.
// Every result leaving the block is compared field by field with the oldest
// queued pixel. Both channels idle and stall at random, first mostly on the
// result side, then mostly on the pixel side, then not at all.
// ----------------------------------------------------------------------------
module testbench;

	// Luma weights, Q0.16
	localparam logic [33:0] LUMA_R = 34'd19589;
	localparam logic [33:0] LUMA_G = 34'd38470;
	localparam logic [33:0] LUMA_B = 34'd7471;

	localparam int RANDOM_PIXELS = 440;
	localparam int SETTLE_CYCLES = 8;

	typedef struct packed {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic        last;
	} pix_res_t;

	typedef enum logic {STEP_PIXEL, STEP_WRITE} step_kind_t;

	typedef struct {
		step_kind_t                       kind;
		logic [rgbgim_pkg::CFG_IDX_W-1:0] idx;
		logic [15:0]                      val;
		logic [15:0]                      red;
		logic [15:0]                      green;
		logic [15:0]                      blue;
		bit                               known;
		pix_res_t                         want;
	} step_t;

	logic                             clk;
	logic                             arst_n    = 1'b0;
	logic                             cfg_we    = 1'b0;
	logic [rgbgim_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [rgbgim_pkg::CFG_W-1:0]     cfg_data  = '0;
	logic                             in_valid  = 1'b0;
	logic                             in_stall;
	logic [15:0]                      red_in    = '0;
	logic [15:0]                      green_in  = '0;
	logic [15:0]                      blue_in   = '0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	logic [15:0]                      red_out;
	logic [15:0]                      green_out;
	logic [15:0]                      blue_out;
	logic                             row_end;

	// Predictor state
	logic [1:0]  tb_mode;
	logic [6:0]  tb_width;
	logic [15:0] tb_max;
	logic [6:0]  col_cnt;
	logic [47:0] line_buf [rgbgim_pkg::MAX_WIDTH];
	pix_res_t    due_pixels[$];
	pix_res_t    fresh_pixels[$];
	step_t       plan[$];

	int errors       = 0;
	int pixels_sent  = 0;
	int results_seen = 0;
	int reg_writes   = 0;
	int mode_hits[4] = '{0, 0, 0, 0};
	int idle_phase   = 0;

	rgb_pixel_gray_invert_mirror dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.row_end   (row_end)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Give up on a hung run
	initial begin
		#20000000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic void note_error(input string msg);
		errors++;
		if (errors <= 10) $display("%s", msg);
	endfunction

	function automatic pix_res_t pixel_of(input logic [15:0] r, g, b, input logic e);
		pixel_of.red   = r;
		pixel_of.green = g;
		pixel_of.blue  = b;
		pixel_of.last  = e;
	endfunction

	function automatic logic [15:0] invert_level(input logic [15:0] c);
		return (tb_max > c) ? tb_max - c : 16'd0;
	endfunction

	function automatic int row_span();
		if (tb_width == 7'd0) return 1;
		if (tb_width > rgbgim_pkg::MAX_WIDTH) return rgbgim_pkg::MAX_WIDTH;
		return int'(tb_width);
	endfunction

	// Advance the predictor by one pixel and collect the pixels it releases
	task automatic apply_pixel(input logic [15:0] r, g, b);
		logic [5:0]  pos;
		logic [6:0]  n;
		logic        last;
		logic [33:0] luma;
		logic [47:0] p;
		pos  = col_cnt[5:0];
		n    = {1'b0, pos} + 7'd1;
		last = (int'(n) >= row_span());
		line_buf[pos] = {r, g, b};
		col_cnt = last ? 7'd0 : n;
		fresh_pixels.delete();
		case (tb_mode)
		rgbgim_pkg::MODE_GRAY: begin
			luma = LUMA_R * r + LUMA_G * g + LUMA_B * b;
			fresh_pixels.push_back(pixel_of(luma[31:16], luma[31:16], luma[31:16], last));
		end
		rgbgim_pkg::MODE_INV: begin
			fresh_pixels.push_back(pixel_of(invert_level(r), invert_level(g),
				invert_level(b), last));
		end
		default: begin
			// Mirror: release the whole row, newest pixel first
			if (last) begin
				for (int k = 0; k < int'(n); k++) begin
					p = line_buf[int'(n) - 1 - k];
					fresh_pixels.push_back(pixel_of(p[47:32], p[31:16], p[15:0],
						k == int'(n) - 1));
				end
			end
		end
		endcase
	endtask

	// Hold the pixel channel low and wait for the block to go quiet
	task automatic settle();
		in_valid <= 1'b0;
		while (due_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [rgbgim_pkg::CFG_IDX_W-1:0] idx,
			input logic [15:0] val);
		if (!cfg_we) settle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
		rgbgim_pkg::CFG_MODE:      tb_mode  = val[1:0];
		rgbgim_pkg::CFG_ROW_WIDTH: tb_width = val[6:0];
		default:                   tb_max   = val;
		endcase
		reg_writes++;
	endtask

	// Offer one pixel request, idling first at random, and queue its results
	task automatic send_pixel(input logic [15:0] r, g, b, input bit known = 1'b0,
			input pix_res_t want = '0);
		int gap_pct;
		gap_pct = (idle_phase == 0) ? 24 : (idle_phase == 1) ? 45 : 0;
		cfg_we <= 1'b0;
		while ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		red_in   <= r;
		green_in <= g;
		blue_in  <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		mode_hits[tb_mode]++;
		apply_pixel(r, g, b);
		if (known) due_pixels.push_back(want);
		else foreach (fresh_pixels[i]) due_pixels.push_back(fresh_pixels[i]);
		pixels_sent++;
		idle_phase = (pixels_sent < 170) ? 0 : (pixels_sent < 340) ? 1 : 2;
	endtask

	function automatic void add_write(input logic [rgbgim_pkg::CFG_IDX_W-1:0] idx,
			input logic [15:0] val);
		step_t s;
		s = '{STEP_WRITE, idx, val, 16'd0, 16'd0, 16'd0, 1'b0, '0};
		plan.push_back(s);
	endfunction

	function automatic void add_pixel(input logic [15:0] r, g, b, input bit known = 1'b0,
			input pix_res_t want = '0);
		step_t s;
		s = '{STEP_PIXEL, '0, 16'd0, r, g, b, known, want};
		plan.push_back(s);
	endfunction

	// Pick a sample, leaning on the extremes and on the max level
	function automatic logic [15:0] pick_level();
		case ($urandom_range(0, 9))
		0:       return 16'h0000;
		1:       return 16'hFFFF;
		2:       return tb_max + 16'($urandom_range(0, 2)) - 16'd1;
		default: return 16'($urandom);
		endcase
	endfunction

	// Stall the result channel according to the idling phase
	always @(posedge clk) begin
		case (idle_phase)
		0:       out_stall <= ($urandom_range(0, 99) < 45);
		1:       out_stall <= ($urandom_range(0, 99) < 24);
		default: out_stall <= 1'b0;
		endcase
	end

	// Compare each result taken with the oldest queued pixel
	always @(posedge clk) begin : check_results
		pix_res_t got;
		pix_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = pixel_of(red_out, green_out, blue_out, row_end);
			results_seen++;
			if (due_pixels.size() == 0) begin
				note_error($sformatf("unexpected result %0d: r=%h g=%h b=%h end=%b",
					results_seen, got.red, got.green, got.blue, got.last));
			end else begin
				want = due_pixels.pop_front();
				if (got.red !== want.red || got.green !== want.green ||
						got.blue !== want.blue || got.last !== want.last) begin
					note_error($sformatf({"mismatch at result %0d: expected r=%h g=%h b=%h ",
						"end=%b, got r=%h g=%h b=%h end=%b"}, results_seen, want.red,
						want.green, want.blue, want.last, got.red, got.green, got.blue,
						got.last));
				end
			end
		end
	end

	initial begin : stimulus
		int span;
		int rows;
		int count;
		tb_mode  = rgbgim_pkg::RST_MODE;
		tb_width = rgbgim_pkg::RST_ROW_WIDTH;
		tb_max   = rgbgim_pkg::RST_MAX_LEVEL;
		col_cnt  = 7'd0;
		foreach (line_buf[i]) line_buf[i] = 48'd0;

		// Grayscale straight after reset, full-scale samples
		add_pixel(16'h0000, 16'h0000, 16'h0000, 1, pixel_of(16'd0, 16'd0, 16'd0, 1'b0));
		add_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1,
			pixel_of(16'd65529, 16'd65529, 16'd65529, 1'b0));
		add_pixel(16'hFFFF, 16'h0000, 16'h0000, 1,
			pixel_of(16'd19588, 16'd19588, 16'd19588, 1'b0));
		// Narrow the row below the pixels already counted
		add_write(rgbgim_pkg::CFG_ROW_WIDTH, 16'd2);
		add_pixel(16'h0000, 16'hFFFF, 16'h0000);
		// Inversion against the default, the largest and a max level of one
		add_write(rgbgim_pkg::CFG_MODE, rgbgim_pkg::MODE_INV);
		add_pixel(16'h0000, 16'h0000, 16'h0000, 1,
			pixel_of(16'd255, 16'd255, 16'd255, 1'b0));
		add_pixel(16'hFFFF, 16'd100, 16'd255, 1, pixel_of(16'd0, 16'd155, 16'd0, 1'b1));
		add_write(rgbgim_pkg::CFG_MAX_LEVEL, 16'hFFFF);
		add_pixel(16'h0000, 16'h0000, 16'h0000, 1,
			pixel_of(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
		add_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1, pixel_of(16'd0, 16'd0, 16'd0, 1'b1));
		add_write(rgbgim_pkg::CFG_MAX_LEVEL, 16'd1);
		add_pixel(16'd1, 16'd0, 16'd2, 1, pixel_of(16'd0, 16'd1, 16'd0, 1'b0));
		// Switch to mirror part-way through a row
		add_write(rgbgim_pkg::CFG_MODE, rgbgim_pkg::MODE_MIRROR);
		add_write(rgbgim_pkg::CFG_ROW_WIDTH, 16'd3);
		add_pixel(16'hAAAA, 16'h5555, 16'h0F0F);
		add_pixel(16'h1234, 16'h8000, 16'h0001);
		// Single-pixel rows, including width zero
		add_write(rgbgim_pkg::CFG_ROW_WIDTH, 16'd1);
		add_pixel(16'hFFFF, 16'h0000, 16'hFFFF);
		add_write(rgbgim_pkg::CFG_ROW_WIDTH, 16'd0);
		add_pixel(16'h0000, 16'hFFFF, 16'h0000);
		// Spare mode code mirrors too
		add_write(rgbgim_pkg::CFG_MODE, rgbgim_pkg::MODE_ALT);
		add_write(rgbgim_pkg::CFG_ROW_WIDTH, 16'd2);
		add_pixel(16'h8001, 16'h4002, 16'h2004);
		add_pixel(16'h7FFE, 16'hBFFD, 16'hDFFB);
		// Mirror row cut short by a narrower width
		add_write(rgbgim_pkg::CFG_MODE, rgbgim_pkg::MODE_MIRROR);
		add_write(rgbgim_pkg::CFG_ROW_WIDTH, 16'd5);
		add_pixel(16'h0101, 16'h0202, 16'h0303);
		add_pixel(16'h1111, 16'h2222, 16'h3333);
		add_pixel(16'hF0F0, 16'h0F0F, 16'hFF00);
		add_write(rgbgim_pkg::CFG_ROW_WIDTH, 16'd2);
		add_pixel(16'h00FF, 16'hFF00, 16'h5A5A);
		// Back to the reset settings
		add_write(rgbgim_pkg::CFG_MODE, rgbgim_pkg::MODE_GRAY);
		add_write(rgbgim_pkg::CFG_ROW_WIDTH, 16'd64);
		add_write(rgbgim_pkg::CFG_MAX_LEVEL, 16'd255);
		add_pixel(16'd1, 16'd1, 16'd1, 1, pixel_of(16'd0, 16'd0, 16'd0, 1'b0));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == STEP_WRITE) write_reg(plan[i].idx, plan[i].val);
			else send_pixel(plan[i].red, plan[i].green, plan[i].blue, plan[i].known,
				plan[i].want);
		end

		// Random phases, each with fresh settings and a few rows
		count = pixels_sent + RANDOM_PIXELS;
		while (pixels_sent < count) begin
			write_reg(rgbgim_pkg::CFG_MODE, 16'($urandom_range(0, 3)));
			if ($urandom_range(0, 2) != 0) begin
				case ($urandom_range(0, 19))
				0:       write_reg(rgbgim_pkg::CFG_ROW_WIDTH, 16'd0);
				1:       write_reg(rgbgim_pkg::CFG_ROW_WIDTH, 16'd64);
				2:       write_reg(rgbgim_pkg::CFG_ROW_WIDTH, 16'($urandom_range(65, 127)));
				3, 4, 5: write_reg(rgbgim_pkg::CFG_ROW_WIDTH, 16'($urandom_range(9, 63)));
				default: write_reg(rgbgim_pkg::CFG_ROW_WIDTH, 16'($urandom_range(1, 8)));
				endcase
			end
			if ($urandom_range(0, 2) != 0) begin
				case ($urandom_range(0, 9))
				0:       write_reg(rgbgim_pkg::CFG_MAX_LEVEL, 16'd0);
				1:       write_reg(rgbgim_pkg::CFG_MAX_LEVEL, 16'd1);
				2:       write_reg(rgbgim_pkg::CFG_MAX_LEVEL, 16'hFFFF);
				3:       write_reg(rgbgim_pkg::CFG_MAX_LEVEL, 16'd255);
				default: write_reg(rgbgim_pkg::CFG_MAX_LEVEL, 16'($urandom_range(1, 65535)));
				endcase
			end
			span = row_span();
			rows = (span > 16) ? 1 : $urandom_range(1, 3);
			rows = rows * span + (($urandom_range(0, 1) != 0) ? $urandom_range(0, span - 1) : 0);
			repeat (rows) send_pixel(pick_level(), pick_level(), pick_level());
		end

		settle();
		repeat (20) @(posedge clk);
		if (due_pixels.size() != 0)
			note_error($sformatf("%0d expected pixels never arrived", due_pixels.size()));

		$display("Sent %0d pixels (gray %0d, invert %0d, mirror %0d) over %0d register writes,",
			pixels_sent, mode_hits[rgbgim_pkg::MODE_GRAY], mode_hits[rgbgim_pkg::MODE_INV],
			mode_hits[rgbgim_pkg::MODE_MIRROR] + mode_hits[rgbgim_pkg::MODE_ALT], reg_writes);
		$display("checked %0d result pixels, %0d mismatches.", results_seen, errors);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/rgbgim_pkg.sv
rtl/rgbgim_front.sv
rtl/rgbgim_queue.sv
rtl/rgbgim_back.sv
rtl/rgb_pixel_gray_invert_mirror.sv
bench/testbench.sv
